/* hdl/sab_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants for the suffix array builder
// no dependencies

package sab_pkg;

   localparam int MAX_LEN_DEF = 1024;
   localparam int OP_W        = 2;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 11;
   localparam int FIELD_W     = 11;
   localparam int ERR_W       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_BUILD  = 2'd1,
      OP_READ   = 2'd2
   } op_code_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 2'd0,
      ERR_INDEX     = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_NOT_BUILT = 2'd3
   } err_code_type;

   typedef enum logic [3:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_PSORT,
      CELL_COPY,
      CELL_SHIFT,
      CELL_KEY,
      CELL_KSORT,
      CELL_RINIT,
      CELL_RANK,
      CELL_COMMIT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        parity;
   } cell_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PSORT,
      ST_COPY,
      ST_SHIFT,
      ST_KEY,
      ST_KSORT,
      ST_RINIT,
      ST_RANK,
      ST_COMMIT,
      ST_STORE,
      ST_READ
   } state_type;

   // packed width of one cell's contents
   function automatic int cell_width(input int pw, input int rw);
      return pw + 4 * rw + 3;
   endfunction

endpackage

/* hdl/sab_cell.sv */
`timescale 1ns / 1ps
// one cell of the sorting chain: a suffix position with its rank keys
// depends on sab_pkg

module sab_cell
   import sab_pkg::*;
#(
   parameter int PW      = 11,
   parameter int RW      = 11,
   parameter bit FIRST   = 1'b0,
   parameter bit LAST    = 1'b0,
   parameter bit IDX_ODD = 1'b0
) (
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic [PW-1:0]                len,
   input  logic [PW-1:0]                ld_pos,
   input  logic                         ld_unused,
   input  logic [RW-1:0]                ld_r1,
   input  logic [cell_width(PW,RW)-1:0] in_l,
   input  logic [cell_width(PW,RW)-1:0] in_r,
   output logic [cell_width(PW,RW)-1:0] out
);

   typedef struct packed {
      logic [PW-1:0] pos;
      logic          unused;
      logic [RW-1:0] r1;
      logic [RW-1:0] key2;
      logic [RW-1:0] cp_rank;
      logic          cp_ok;
      logic [RW-1:0] nrank;
      logic          done;
   } data_type;

   data_type cell_ff, cell_in, l, r;
   logic     right_side, has_partner;
   logic [2*RW:0] key_s, key_l, key_r;

   always_comb begin
      l = in_l;
      r = in_r;
      key_s = {cell_ff.unused, cell_ff.r1, cell_ff.key2};
      key_l = {l.unused, l.r1, l.key2};
      key_r = {r.unused, r.r1, r.key2};
      right_side  = (IDX_ODD == ctl.parity);
      has_partner = right_side ? !LAST : !FIRST;
      cell_in = cell_ff;
      case (ctl.op)
         CELL_LOAD: begin
            if (LAST) begin
               cell_in.pos    = ld_pos;
               cell_in.unused = ld_unused;
               cell_in.r1     = ld_r1;
            end else begin
               cell_in = r;
            end
         end
         CELL_ROTATE: cell_in = r;
         CELL_PSORT: begin
            if (has_partner) begin
               if (right_side && cell_ff.pos > r.pos) cell_in = r;
               else if (!right_side && l.pos > cell_ff.pos) cell_in = l;
            end
         end
         CELL_KSORT: begin
            if (has_partner) begin
               if (right_side && key_s > key_r) cell_in = r;
               else if (!right_side && key_l > key_s) cell_in = l;
            end
         end
         CELL_COPY: begin
            cell_in.cp_rank = cell_ff.r1;
            cell_in.cp_ok   = cell_ff.pos < len;
         end
         CELL_SHIFT: begin
            if (LAST) begin
               cell_in.cp_ok = 1'b0;
            end else begin
               cell_in.cp_rank = r.cp_rank;
               cell_in.cp_ok   = r.cp_ok;
            end
         end
         CELL_KEY: cell_in.key2 = cell_ff.cp_ok ? cell_ff.cp_rank + RW'(1) : '0;
         CELL_RINIT: begin
            cell_in.nrank = '0;
            cell_in.done  = FIRST;
         end
         CELL_RANK: begin
            // rank ripples down the sorted chain
            if (!FIRST && !cell_ff.done && l.done) begin
               cell_in.nrank = l.nrank + RW'(key_l != key_s);
               cell_in.done  = 1'b1;
            end
         end
         CELL_COMMIT: cell_in.r1 = cell_ff.nrank;
         default: cell_in = cell_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign out = cell_ff;

endmodule

/* hdl/suffix_array_builder_unit.sv */
`timescale 1ns / 1ps
// top level of the suffix array builder: command port, sequencer, memories
// depends on sab_pkg and sab_cell

// Appends never raise busy. An end beat loads the text into a chain of
// MAX_LEN+1 cells, then runs one prefix doubling round per doubling of k
// while k <= length; each round runs the odd-even transposition sort in
// the chain (once by position, once by rank pair) and the rank ripple.
// The finished order is then copied to the order memory and the end
// result is strobed. A read that passes its checks answers through the
// registered order memory and then the result register; a failed read
// answers on the next cycle. busy is high for the whole build and for one
// cycle of a read that passes its checks. Results appear for exactly one
// cycle on rsp_strobe; the receiver cannot stall.

module suffix_array_builder_unit
   import sab_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [BYTE_W-1:0]  req_byte_value,
   input  logic [IDX_W-1:0]   req_read_index,
   output logic               rsp_strobe,
   output logic [FIELD_W-1:0] rsp_position,
   output logic [FIELD_W-1:0] rsp_text_length,
   output logic [ERR_W-1:0]   rsp_error_code
);

   localparam int D   = MAX_LEN + 1;                   // cells, including empty suffix
   localparam int PW  = $clog2(D);                     // position width
   localparam int CW  = $clog2(D + 1);                 // counter width
   localparam int RW  = (CW > 9) ? CW : 9;             // rank width
   localparam int KW  = CW + 1;
   localparam int TW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DW  = cell_width(PW, RW);

   state_type     state_ff, state_in;
   cell_ctl_type  ctl;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] k_ff, k_in;
   logic [PW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic          built_ff, built_in;
   logic [PW-1:0] pos_d_ff;
   logic          accept;
   logic          last_cnt;

   // storage
   logic [BYTE_W-1:0] text_mem [MAX_LEN];
   logic [PW-1:0]     order_mem [D];
   logic [BYTE_W-1:0] text_rd_ff;
   logic [PW-1:0]     order_rd_ff;

   // result registers
   logic               rsp_strobe_ff;
   logic [FIELD_W-1:0] rsp_position_ff;
   logic [FIELD_W-1:0] rsp_text_length_ff;
   err_code_type       rsp_error_ff;

   // chain
   logic [DW-1:0] cell_out [D];
   logic [PW-1:0] ld_pos;
   logic          ld_unused;
   logic [RW-1:0] ld_r1;
   logic [PW-1:0] head_pos;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign head_pos = cell_out[0][DW-1 -: PW];

   // tail input during load, taken from the registered text read and its delayed position
   assign ld_pos    = pos_d_ff;
   assign ld_unused = pos_d_ff > len_ff;
   assign ld_r1     = (pos_d_ff < len_ff) ? RW'(text_rd_ff) + RW'(1) : '0;

   always_comb begin
      case (state_ff) inside
         ST_LOAD:  last_cnt = (cnt_ff == CW'(D));
         ST_PSORT, ST_KSORT, ST_STORE: last_cnt = (cnt_ff == CW'(D - 1));
         ST_RANK:  last_cnt = (cnt_ff == CW'(D - 2));
         ST_SHIFT: last_cnt = (KW'(cnt_ff) == k_ff - KW'(1));
         default:  last_cnt = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_BUILD) state_in = ST_LOAD;
            else if (accept && req_operation == OP_READ && built_ff &&
                     32'(req_read_index) <= 32'(len_ff)) state_in = ST_READ;
         end
         ST_LOAD:   if (last_cnt) state_in = (len_ff != '0) ? ST_PSORT : ST_STORE;
         ST_PSORT:  if (last_cnt) state_in = ST_COPY;
         ST_COPY:   state_in = ST_SHIFT;
         ST_SHIFT:  if (last_cnt) state_in = ST_KEY;
         ST_KEY:    state_in = ST_KSORT;
         ST_KSORT:  if (last_cnt) state_in = ST_RINIT;
         ST_RINIT:  state_in = ST_RANK;
         ST_RANK:   if (last_cnt) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ({k_ff, 1'b0} <= (KW+1)'(len_ff)) ? ST_PSORT : ST_STORE;
         ST_STORE:  if (last_cnt) state_in = ST_IDLE;
         ST_READ:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // cell commands
   always_comb begin
      ctl.op     = CELL_HOLD;
      ctl.parity = cnt_ff[0];
      unique case (state_ff)
         ST_LOAD:   ctl.op = (cnt_ff != '0) ? CELL_LOAD : CELL_HOLD;
         ST_PSORT:  ctl.op = CELL_PSORT;
         ST_COPY:   ctl.op = CELL_COPY;
         ST_SHIFT:  ctl.op = CELL_SHIFT;
         ST_KEY:    ctl.op = CELL_KEY;
         ST_KSORT:  ctl.op = CELL_KSORT;
         ST_RINIT:  ctl.op = CELL_RINIT;
         ST_RANK:   ctl.op = CELL_RANK;
         ST_COMMIT: ctl.op = CELL_COMMIT;
         ST_STORE:  ctl.op = CELL_ROTATE;
         default:   ctl.op = CELL_HOLD;
      endcase
   end

   // counters and text state
   always_comb begin
      cnt_in   = (state_in != state_ff || last_cnt) ? '0 : cnt_ff + CW'(1);
      k_in     = k_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      built_in = built_ff;
      if (state_ff == ST_LOAD) k_in = KW'(1);
      if (state_ff == ST_COMMIT) k_in = {k_ff[KW-2:0], 1'b0};
      if (state_ff == ST_STORE && last_cnt) built_in = 1'b1;
      if (accept && req_operation == OP_APPEND) begin
         if (built_ff) begin
            // an append after a build starts a new text
            built_in = 1'b0;
            ovf_in   = 1'b0;
            len_in   = PW'(1);
         end else if (32'(len_ff) < MAX_LEN) begin
            len_in = len_ff + PW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         k_ff     <= KW'(1);
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         built_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         built_ff <= built_in;
      end
   end

   // text memory
   always_ff @(posedge clock) begin
      if (accept && req_operation == OP_APPEND) begin
         if (built_ff) text_mem[0] <= req_byte_value;
         else if (32'(len_ff) < MAX_LEN) text_mem[len_ff[TW-1:0]] <= req_byte_value;
      end
      text_rd_ff <= text_mem[cnt_ff[TW-1:0]];
      pos_d_ff   <= PW'(cnt_ff);
   end

   // order memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) order_mem[cnt_ff[PW-1:0]] <= head_pos;
      order_rd_ff <= order_mem[PW'(req_read_index)];
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (state_ff == ST_STORE && last_cnt) begin
            rsp_strobe_ff      <= 1'b1;
            rsp_position_ff    <= '0;
            rsp_text_length_ff <= FIELD_W'(len_ff);
            rsp_error_ff       <= ovf_ff ? ERR_OVERFLOW : ERR_NONE;
         end else if (state_ff == ST_READ) begin
            rsp_strobe_ff      <= 1'b1;
            rsp_position_ff    <= FIELD_W'(order_rd_ff);
            rsp_text_length_ff <= FIELD_W'(len_ff);
            rsp_error_ff       <= ERR_NONE;
         end else if (accept && req_operation == OP_READ && !built_ff) begin
            rsp_strobe_ff      <= 1'b1;
            rsp_position_ff    <= '0;
            rsp_text_length_ff <= FIELD_W'(len_ff);
            rsp_error_ff       <= ERR_NOT_BUILT;
         end else if (accept && req_operation == OP_READ &&
                      32'(req_read_index) > 32'(len_ff)) begin
            rsp_strobe_ff      <= 1'b1;
            rsp_position_ff    <= '0;
            rsp_text_length_ff <= FIELD_W'(len_ff);
            rsp_error_ff       <= ERR_INDEX;
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_text_length = rsp_text_length_ff;
   assign rsp_error_code  = rsp_error_ff;

   // chain of cells; the tail wraps to the head for the rotate pass
   for (genvar g = 0; g < D; g++) begin : g_cell
      logic [DW-1:0] nb_l, nb_r;
      if (g == 0) begin : g_head
         assign nb_l = '0;
      end else begin : g_mid_l
         assign nb_l = cell_out[g-1];
      end
      if (g == D - 1) begin : g_tail
         assign nb_r = cell_out[0];
      end else begin : g_mid_r
         assign nb_r = cell_out[g+1];
      end
      sab_cell #(
         .PW      (PW),
         .RW      (RW),
         .FIRST   (g == 0),
         .LAST    (g == D - 1),
         .IDX_ODD ((g % 2) == 1)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .len       (len_ff),
         .ld_pos    (ld_pos),
         .ld_unused (ld_unused),
         .ld_r1     (ld_r1),
         .in_l      (nb_l),
         .in_r      (nb_r),
         .out       (cell_out[g])
      );
   end

   // results only leave while the sequencer is idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result beat while busy");

   // an end beat always starts a build
   a_build_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_BUILD) |=> (state_ff == ST_LOAD))
      else $error("build did not start");

   // a clean result means the array was built
   a_ok_built: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error_code == ERR_NONE) |-> built_ff)
      else $error("ok result without a build");

   // doubling step never exceeds the text length inside a round
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PSORT) |-> (32'(k_ff) <= 32'(len_ff)))
      else $error("doubling step beyond length");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for suffix_array_builder_unit: directed table, overflow, random texts
// depends on sab_pkg and the suffix_array_builder_unit rtl

module tb_top;
   import sab_pkg::*;

   localparam int                TEXT_MAX   = MAX_LEN_DEF;
   localparam logic [OP_W-1:0]   OP_IGNORED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_operation  = '0;
   logic [BYTE_W-1:0]  req_byte_value = '0;
   logic [IDX_W-1:0]   req_read_index = '0;
   logic               rsp_strobe;
   logic [FIELD_W-1:0] rsp_position;
   logic [FIELD_W-1:0] rsp_text_length;
   logic [ERR_W-1:0]   rsp_error_code;

   suffix_array_builder_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_byte_value(req_byte_value),
      .req_read_index(req_read_index), .rsp_strobe(rsp_strobe),
      .rsp_position(rsp_position), .rsp_text_length(rsp_text_length),
      .rsp_error_code(rsp_error_code)
   );

   always #2 clock = ~clock;

   // one expected response beat
   typedef struct {
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] text_length;
      err_code_type       error_code;
   } answer_type;

   answer_type answer_q[$];

   // mirror of the block's text and finished suffix order
   logic [BYTE_W-1:0]  text_mem [TEXT_MAX];
   logic [FIELD_W-1:0] sa_mem   [TEXT_MAX+1];
   int                 text_len   = 0;
   bit                 text_ovf   = 0;
   bit                 text_built = 0;

   int errors      = 0;
   int items_sent  = 0;
   int answers_ok  = 0;
   int builds_done = 0;

   // lexicographic order of suffixes at a and b, unsigned bytes, shorter first
   function automatic bit suffix_less(input int a, input int b);
      int i;
      i = 0;
      while (a + i < text_len && b + i < text_len) begin
         if (text_mem[a+i] != text_mem[b+i]) return text_mem[a+i] < text_mem[b+i];
         i++;
      end
      return (a + i >= text_len) && (b + i < text_len);
   endfunction

   // ranks end up unique, so the true suffix array is what the block holds
   function automatic void build_suffix_order();
      int i, j, p;
      for (i = 0; i <= text_len; i++) begin
         p = i;
         j = i - 1;
         while (j >= 0 && suffix_less(p, sa_mem[j])) begin
            sa_mem[j+1] = sa_mem[j];
            j--;
         end
         sa_mem[j+1] = p[FIELD_W-1:0];
      end
      text_built = 1;
   endfunction

   // state update for one accepted beat; returns 1 with the answer if one is due
   function automatic bit predict_beat(input logic [OP_W-1:0] op, input logic [7:0] b,
                                       input logic [IDX_W-1:0] idx, output answer_type ans);
      ans.position    = '0;
      ans.text_length = text_len[FIELD_W-1:0];
      ans.error_code  = ERR_NONE;
      case (op)
         OP_APPEND: begin
            if (text_built) begin
               text_built = 0;
               text_len   = 0;
               text_ovf   = 0;
            end
            if (text_len < TEXT_MAX) begin
               text_mem[text_len] = b;
               text_len++;
            end else begin
               text_ovf = 1;
            end
            return 0;
         end
         OP_BUILD: begin
            build_suffix_order();
            if (text_ovf) ans.error_code = ERR_OVERFLOW;
            return 1;
         end
         OP_READ: begin
            if (!text_built) ans.error_code = ERR_NOT_BUILT;
            else if (idx > text_len) ans.error_code = ERR_INDEX;
            else ans.position = sa_mem[idx];
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // drive one command beat after a random gap; returns at the accepting edge
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [7:0] b,
                            input logic [IDX_W-1:0] idx, input bit typed,
                            input answer_type typed_ans);
      int         gap;
      answer_type ans;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;   // back-to-back stretches
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_byte_value <= b;
      req_read_index <= idx;
      // busy only moves on rising edges, so the falling edge sees it settled
      do @(negedge clock); while (busy);
      @(posedge clock);
      items_sent++;
      if (predict_beat(op, b, idx, ans)) begin
         if (op == OP_BUILD) builds_done++;
         answer_q.push_back(typed ? typed_ans : ans);
      end
   endtask

   // response checker, sampled mid-cycle away from the driving edge
   always @(negedge clock) begin
      answer_type exp_a;
      if (!reset && rsp_strobe) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected response pos=%0d len=%0d err=%0d", $time,
                     rsp_position, rsp_text_length, rsp_error_code);
            errors++;
         end else begin
            exp_a = answer_q.pop_front();
            if (rsp_position !== exp_a.position) begin
               $display("%0t: position expected %0d actual %0d", $time,
                        exp_a.position, rsp_position);
               errors++;
            end
            if (rsp_text_length !== exp_a.text_length) begin
               $display("%0t: text_length expected %0d actual %0d", $time,
                        exp_a.text_length, rsp_text_length);
               errors++;
            end
            if (rsp_error_code !== exp_a.error_code) begin
               $display("%0t: error_code expected %0d actual %0d", $time,
                        exp_a.error_code, rsp_error_code);
               errors++;
            end
            answers_ok++;
         end
      end
   end

   // directed table row; chk marks a hand-typed answer
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [7:0]         b;
      logic [IDX_W-1:0]   idx;
      bit                 chk;
      logic [FIELD_W-1:0] pos;
      logic [FIELD_W-1:0] len;
      err_code_type       err;
   } row_type;

   localparam int NUM_ROWS = 24;
   row_type dir_rows [NUM_ROWS] = '{
      '{OP_READ,     8'd0,   11'd0,   1'b1, 11'd0, 11'd0, ERR_NOT_BUILT}, // read before build
      '{OP_BUILD,    8'd0,   11'd0,   1'b1, 11'd0, 11'd0, ERR_NONE},      // empty text
      '{OP_READ,     8'd0,   11'd0,   1'b1, 11'd0, 11'd0, ERR_NONE},      // only the empty suffix
      '{OP_READ,     8'd0,   11'd1,   1'b1, 11'd0, 11'd0, ERR_INDEX},
      '{OP_APPEND,   8'd255, 11'd0,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_APPEND,   8'd0,   11'd0,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_APPEND,   8'd255, 11'd0,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_APPEND,   8'd0,   11'd0,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_APPEND,   8'd128, 11'd0,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_READ,     8'd0,   11'd2,   1'b1, 11'd0, 11'd5, ERR_NOT_BUILT},
      '{OP_BUILD,    8'd0,   11'd0,   1'b1, 11'd0, 11'd5, ERR_NONE},
      '{OP_READ,     8'd0,   11'd0,   1'b1, 11'd5, 11'd5, ERR_NONE},      // empty suffix first
      '{OP_READ,     8'd0,   11'd1,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_READ,     8'd0,   11'd3,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_READ,     8'd0,   11'd5,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_READ,     8'd0,   11'd6,   1'b1, 11'd0, 11'd5, ERR_INDEX},
      '{OP_READ,     8'd0,   11'h7FF, 1'b1, 11'd0, 11'd5, ERR_INDEX},
      '{OP_IGNORED,  8'hFF,  11'h7FF, 1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_BUILD,    8'd0,   11'd0,   1'b1, 11'd0, 11'd5, ERR_NONE},      // rebuild same text
      '{OP_READ,     8'd0,   11'd4,   1'b0, 11'd0, 11'd0, ERR_NONE},
      '{OP_APPEND,   8'd7,   11'd0,   1'b0, 11'd0, 11'd0, ERR_NONE},      // new text after build
      '{OP_READ,     8'd0,   11'd0,   1'b1, 11'd0, 11'd1, ERR_NOT_BUILT},
      '{OP_BUILD,    8'd0,   11'd0,   1'b1, 11'd0, 11'd1, ERR_NONE},
      '{OP_READ,     8'd0,   11'd1,   1'b1, 11'd0, 11'd1, ERR_NONE}       // position 0 is 'byte'
   };

   initial begin
      answer_type typed_ans;
      int      i, n, reads, alpha;
      logic [IDX_W-1:0] ridx;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (i = 0; i < NUM_ROWS; i++) begin
         typed_ans.position    = dir_rows[i].pos;
         typed_ans.text_length = dir_rows[i].len;
         typed_ans.error_code  = dir_rows[i].err;
         send_beat(dir_rows[i].op, dir_rows[i].b, dir_rows[i].idx, dir_rows[i].chk,
                   typed_ans);
      end

      // full text plus one dropped byte, then the overflow flag on build
      for (i = 0; i <= TEXT_MAX; i++)
         send_beat(OP_APPEND, 8'($urandom_range(0, 255)), '0, 1'b0, typed_ans);
      typed_ans.position    = '0;
      typed_ans.text_length = FIELD_W'(TEXT_MAX);
      typed_ans.error_code  = ERR_OVERFLOW;
      send_beat(OP_BUILD, '0, '0, 1'b1, typed_ans);
      send_beat(OP_READ, '0, IDX_W'(TEXT_MAX), 1'b0, typed_ans);
      send_beat(OP_READ, '0, IDX_W'(TEXT_MAX + 1), 1'b0, typed_ans);
      for (i = 0; i < 6; i++)
         send_beat(OP_READ, '0, IDX_W'($urandom_range(0, TEXT_MAX)), 1'b0, typed_ans);

      // random texts: short append runs, then mostly a build and a burst of reads
      while (items_sent < 1200) begin
         if ($urandom_range(0, 5) == 0)
            send_beat(OP_IGNORED, 8'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(0, 2047)), 1'b0, typed_ans);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         alpha = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 3);
         for (i = 0; i < n; i++)
            send_beat(OP_APPEND, (alpha == 255) ? 8'($urandom_range(0, 255))
                                 : 8'(97 + $urandom_range(0, alpha)), '0, 1'b0, typed_ans);
         // occasionally read unbuilt or keep extending the same text
         if ($urandom_range(0, 9) == 0)
            send_beat(OP_READ, '0, IDX_W'($urandom_range(0, 2047)), 1'b0, typed_ans);
         if ($urandom_range(0, 7) != 0) begin
            send_beat(OP_BUILD, '0, '0, 1'b0, typed_ans);
            if ($urandom_range(0, 9) == 0) send_beat(OP_BUILD, '0, '0, 1'b0, typed_ans);
            reads = $urandom_range(15, 30);
            for (i = 0; i < reads; i++) begin
               ridx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(0, 2047))
                                                  : IDX_W'($urandom_range(0, text_len));
               send_beat(OP_READ, 8'($urandom_range(0, 255)), ridx, 1'b0, typed_ans);
            end
         end
      end

      // drop start at the last accepting edge so no beat repeats
      start <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (answer_q.size() != 0) errors++;

      $display("covered %0d command beats and %0d builds, %0d responses checked",
               items_sent, builds_done, answers_ok);
      if (errors == 0) begin
         $display("suffix_array_builder_unit test passed");
      end else begin
         $display("suffix_array_builder_unit test failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #40ms;
      $display("suffix_array_builder_unit test failed");
      $finish;
   end

endmodule
